### hdl/oest_pkg.sv
// oest_pkg: shared types and codes for the oldest entry swap table
// no dependencies; imported by every module of the block but oest_ram

package oest_pkg;

  localparam int ID_W          = 16;
  localparam int TIME_W        = 32;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;
  localparam int SLOT_W        = ID_W + TIME_W;

  // request command
  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  // result status code
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // sequencer to scan unit
  typedef struct packed {
    logic start;
    logic eval;
    logic slot_valid;
  } scan_ctl_t;

  // scan unit to sequencer
  typedef struct packed {
    logic              hit;
    logic              free_found;
    logic              best_found;
    logic [ID_W-1:0]   best_id;
    logic [TIME_W-1:0] best_time;
  } scan_flags_t;

endpackage

### hdl/oest_ifs.sv
// oest_ifs: valid/ready channels for requests and results
// depends on oest_pkg for payload widths

interface oest_in_if;
  import oest_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ID_W-1:0]   item_id;
  logic [TIME_W-1:0] now_tick;

  modport source (output valid, cmd, item_id, now_tick, input ready);
  modport sink   (input valid, cmd, item_id, now_tick, output ready);
endinterface

interface oest_out_if;
  import oest_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     any_valid;
  logic [ID_W-1:0]          oldest_id;
  logic [TIME_W-1:0]        oldest_time;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, status, any_valid, oldest_id, oldest_time, entry_count,
                  input ready);
  modport sink   (input valid, status, any_valid, oldest_id, oldest_time, entry_count,
                  output ready);
endinterface

### hdl/oest_ram.sv
// oest_ram: generic single write port, single read port ram, registered read
// no dependencies

module oest_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/oest_scan.sv
// oest_scan: per-slot match, free slot and oldest entry accumulator
// depends on oest_pkg; fed one slot a cycle by the sequencer

module oest_scan #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  oest_pkg::scan_ctl_t            ctl,
  input  logic [$clog2(TABLE_DEPTH)-1:0] slot_idx,
  input  logic [oest_pkg::ID_W-1:0]      slot_id,
  input  logic [oest_pkg::TIME_W-1:0]    slot_time,
  input  logic                           req_cmd,
  input  logic [oest_pkg::ID_W-1:0]      req_id,
  output oest_pkg::scan_flags_t          flags,
  output logic [$clog2(TABLE_DEPTH)-1:0] hit_idx,
  output logic [$clog2(TABLE_DEPTH)-1:0] free_idx
);
  import oest_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic              hit_r, hit_nxt;
  logic              free_found_r, free_found_nxt;
  logic              best_found_r, best_found_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [ID_W-1:0]   best_id_r, best_id_nxt;
  logic [TIME_W-1:0] best_time_r, best_time_nxt;

  logic id_match;
  logic cand;
  logic older;

  assign id_match = ctl.slot_valid && (slot_id == req_id);
  // a slot being removed takes no part in the oldest search
  assign cand  = ctl.slot_valid && !(req_cmd == CMD_REMOVE && slot_id == req_id);
  assign older = !best_found_r || (slot_time < best_time_r) ||
                 ((slot_time == best_time_r) && (slot_id < best_id_r));

  always_comb begin
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    best_found_nxt = best_found_r;
    best_id_nxt    = best_id_r;
    best_time_nxt  = best_time_r;
    if (ctl.start) begin
      hit_nxt        = 1'b0;
      free_found_nxt = 1'b0;
      best_found_nxt = 1'b0;
    end else if (ctl.eval) begin
      if (id_match) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = slot_idx;
      end
      // lowest free slot wins, scan runs upwards
      if (!ctl.slot_valid && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = slot_idx;
      end
      if (cand && older) begin
        best_found_nxt = 1'b1;
        best_id_nxt    = slot_id;
        best_time_nxt  = slot_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
      best_found_r <= best_found_nxt;
    end
    hit_idx_r   <= hit_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    best_id_r   <= best_id_nxt;
    best_time_r <= best_time_nxt;
  end

  assign flags.hit        = hit_r;
  assign flags.free_found = free_found_r;
  assign flags.best_found = best_found_r;
  assign flags.best_id    = best_id_r;
  assign flags.best_time  = best_time_r;
  assign hit_idx          = hit_idx_r;
  assign free_idx         = free_idx_r;

endmodule

### hdl/oldest_entry_swap_table.sv
// oldest_entry_swap_table: bounded table of swapped-out processes with oldest entry report.
// Each request adds (id, arrival time) or removes an id; one result follows every request
// with a status, the oldest entry (earliest time, lowest id on a tie), a non-empty flag and
// the entry count. Ids and times live in one ram read one slot a cycle; valid bits are
// flip-flops cleared by reset, so no clearing pass is needed. A request is accepted in
// S_IDLE, scanned through the ram read port in S_SCAN, then written back in S_FINISH, which
// also loads the result register and waits while an untaken result still sits there. A new
// request is taken while the previous result still waits in the output register.
// depends on oest_pkg, oest_ifs, oest_ram and oest_scan

module oldest_entry_swap_table #(
  parameter int TABLE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  oest_in_if.sink   in_chan,
  oest_out_if.source out_chan
);
  import oest_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // sequencer
  state_t state_r, state_nxt;

  // captured request
  logic              req_cmd_r;
  logic [ID_W-1:0]   req_id_r;
  logic [TIME_W-1:0] req_time_r;

  // scan address counter and read pipeline tag
  logic [IDX_W:0]   cnt_r, cnt_nxt;
  logic             pipe_vld_r, pipe_vld_nxt;
  logic [IDX_W-1:0] pipe_idx_r;

  // table state outside the ram
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;

  // result register
  logic                     out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0]      out_status_r;
  logic                     out_any_r;
  logic [ID_W-1:0]          out_id_r;
  logic [TIME_W-1:0]        out_time_r;
  logic [ENTRY_COUNT_W-1:0] out_count_r;

  // ram and scan wiring
  logic              rd_en;
  logic [SLOT_W-1:0] rd_data;
  logic              wr_en;
  scan_ctl_t         scan_ctl;
  scan_flags_t       flags;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  free_idx;

  // finish-cycle decisions
  logic             accept;
  logic             scan_last;
  logic             load;
  logic             add_ok;
  logic             rem_ok;
  status_t          status_c;
  logic             new_older;
  logic             res_any;
  logic [ID_W-1:0]  res_id;
  logic [TIME_W-1:0] res_time;

  assign accept    = in_chan.valid && in_chan.ready;
  assign scan_last = (cnt_r == (IDX_W + 1)'(TABLE_DEPTH));
  // result register must be free or emptying before the write-back commits
  assign load      = (state_r == S_FINISH) && (!out_vld_r || out_chan.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_chan.ready       = 1'b0;
    rd_en               = 1'b0;
    cnt_nxt             = cnt_r;
    pipe_vld_nxt        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_chan.ready  = 1'b1;
        cnt_nxt        = '0;
      end
      S_SCAN: begin
        if (!scan_last) begin
          rd_en        = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          pipe_vld_nxt = 1'b1;
        end
      end
      S_FINISH: begin
        cnt_nxt = cnt_r;
      end
      default: cnt_nxt = '0;
    endcase
  end

  // accumulators clear as a request is taken
  assign scan_ctl.start      = accept;
  // slot data from the registered ram read is evaluated as it arrives
  assign scan_ctl.eval       = pipe_vld_r;
  assign scan_ctl.slot_valid = valid_r[pipe_idx_r];

  // outcome of the request
  assign add_ok = (req_cmd_r == CMD_ADD) && !flags.hit && flags.free_found;
  assign rem_ok = (req_cmd_r == CMD_REMOVE) && flags.hit;

  always_comb begin
    priority if (req_cmd_r == CMD_REMOVE) begin
      status_c = flags.hit ? ST_OK : ST_NOT_FOUND;
    end else if (flags.hit) begin
      status_c = ST_DUPLICATE;
    end else if (!flags.free_found) begin
      status_c = ST_FULL;
    end else begin
      status_c = ST_OK;
    end
  end

  // the newly added entry may be older than everything already held
  assign new_older = !flags.best_found || (req_time_r < flags.best_time) ||
                     ((req_time_r == flags.best_time) && (req_id_r < flags.best_id));

  always_comb begin
    res_any  = flags.best_found;
    res_id   = flags.best_found ? flags.best_id : '0;
    res_time = flags.best_found ? flags.best_time : '0;
    if (add_ok && new_older) begin
      res_any  = 1'b1;
      res_id   = req_id_r;
      res_time = req_time_r;
    end
  end

  // table update at write-back
  assign wr_en = load && add_ok;

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (load && add_ok) begin
      valid_nxt[free_idx] = 1'b1;
      count_nxt           = count_r + 1'b1;
    end else if (load && rem_ok) begin
      valid_nxt[hit_idx] = 1'b0;
      count_nxt          = count_r - 1'b1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      pipe_vld_r <= 1'b0;
      valid_r    <= '0;
      count_r    <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pipe_vld_r <= pipe_vld_nxt;
      valid_r    <= valid_nxt;
      count_r    <= count_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pipe_idx_r <= cnt_r[IDX_W-1:0];
    if (accept) begin
      req_cmd_r  <= in_chan.cmd;
      req_id_r   <= in_chan.item_id;
      req_time_r <= in_chan.now_tick;
    end
    if (load) begin
      out_status_r <= status_c;
      out_any_r    <= res_any;
      out_id_r     <= res_id;
      out_time_r   <= res_time;
      out_count_r  <= ENTRY_COUNT_W'(count_nxt);
    end
  end

  // slot store: id in the upper bits, arrival time below
  oest_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx),
    .wr_data ({req_id_r, req_time_r}),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  oest_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .slot_idx  (pipe_idx_r),
    .slot_id   (rd_data[SLOT_W-1:TIME_W]),
    .slot_time (rd_data[TIME_W-1:0]),
    .req_cmd   (req_cmd_r),
    .req_id    (req_id_r),
    .flags     (flags),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx)
  );

  assign out_chan.valid       = out_vld_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.any_valid   = out_any_r;
  assign out_chan.oldest_id   = out_id_r;
  assign out_chan.oldest_time = out_time_r;
  assign out_chan.entry_count = out_count_r;

endmodule

### hdl/oest_checker.sv
// oest_checker: port-level assertions for the oldest entry swap table, with its bind
// depends on oest_pkg; bound to oldest_entry_swap_table

module oest_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [oest_pkg::STATUS_W-1:0]      out_status,
  input logic                               out_any_valid,
  input logic [oest_pkg::ID_W-1:0]          out_oldest_id,
  input logic [oest_pkg::TIME_W-1:0]        out_oldest_time,
  input logic [oest_pkg::ENTRY_COUNT_W-1:0] out_entry_count
);
  import oest_pkg::*;

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_oldest_id))
    else $error("result dropped or changed while stalled");

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in flight");

  // an empty table reports zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_valid |->
      out_oldest_id == '0 && out_oldest_time == '0 && out_entry_count == '0)
    else $error("empty table with non-zero result fields");

  // a refused add on a full table reports a full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_any_valid && out_entry_count == ENTRY_COUNT_W'(TABLE_DEPTH))
    else $error("full status without a full table");

endmodule

bind oldest_entry_swap_table oest_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_oest_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_any_valid   (out_chan.any_valid),
  .out_oldest_id   (out_chan.oldest_id),
  .out_oldest_time (out_chan.oldest_time),
  .out_entry_count (out_chan.entry_count)
);

### test/tb_top.sv
// tb_top: self-checking testbench for oldest_entry_swap_table
// drives requests, predicts each result from its own copy of the table and checks every field
// depends on oest_pkg, oest_ifs and the oldest_entry_swap_table rtl
`timescale 1ns / 100ps

module tb_top;
  import oest_pkg::*;

  localparam int DEPTH          = 16;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int POOL_SIZE      = 24;
  localparam int IDLE_PCT       = 11;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT        = 700;
  localparam int CALM_FROM      = 1100;
  localparam int CALM_TO        = 1400;
  localparam int TIMEOUT_CYCLES = 400000;

  // one request as offered on the input channel
  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   item_id;
    logic [TIME_W-1:0] now_tick;
  } swap_request_t;

  // one result as it should appear on the output channel
  typedef struct packed {
    status_t                  status;
    logic                     any_valid;
    logic [ID_W-1:0]          oldest_id;
    logic [TIME_W-1:0]        oldest_time;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } oldest_report_t;

  logic clk = 1'b0;
  logic rst_n;

  oest_in_if  req_if ();
  oest_out_if res_if ();

  oldest_entry_swap_table #(
    .TABLE_DEPTH (DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if.sink),
    .out_chan (res_if.source)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // requests waiting to be offered, and reports still owed by the block
  swap_request_t  pending_requests[$];
  oldest_report_t owed_reports[$];

  // shadow copy of the table, updated as each request is accepted
  logic              shadow_valid[DEPTH];
  logic [ID_W-1:0]   shadow_id[DEPTH];
  logic [TIME_W-1:0] shadow_arrival[DEPTH];

  int errors            = 0;
  int accepted_requests = 0;
  int results_seen      = 0;
  int cycle_count       = 0;
  int status_hits[4]    = '{0, 0, 0, 0};
  int full_reports      = 0;

  swap_request_t staged_req;
  swap_request_t taken_req;
  oldest_report_t owed;

  // receiver hold-off state
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic calm_stretch;

  // no idling on either side while this window of results goes by
  assign calm_stretch = (results_seen >= CALM_FROM) && (results_seen < CALM_TO);

  // ---------------------------------------------------------------------------
  // table predictor: applies one request to the shadow table and returns the
  // report the block must give for it
  // ---------------------------------------------------------------------------
  function automatic oldest_report_t apply_swap_request(swap_request_t rq);
    oldest_report_t rep;
    int hit_slot;
    int free_slot;
    int live;
    bit have_best;
    hit_slot  = -1;
    free_slot = -1;
    live      = 0;
    have_best = 1'b0;
    rep       = '0;
    rep.status = ST_OK;

    for (int s = 0; s < DEPTH; s++) begin
      if (hit_slot < 0 && shadow_valid[s] && shadow_id[s] == rq.item_id) hit_slot = s;
      if (free_slot < 0 && !shadow_valid[s]) free_slot = s;
    end

    if (rq.cmd == CMD_ADD) begin
      // duplicate check wins over the full check
      if (hit_slot >= 0) begin
        rep.status = ST_DUPLICATE;
      end else if (free_slot < 0) begin
        rep.status = ST_FULL;
      end else begin
        // lowest free slot takes the new entry
        shadow_valid[free_slot]   = 1'b1;
        shadow_id[free_slot]      = rq.item_id;
        shadow_arrival[free_slot] = rq.now_tick;
      end
    end else begin
      if (hit_slot < 0) rep.status = ST_NOT_FOUND;
      else shadow_valid[hit_slot] = 1'b0;
    end

    // earliest arrival, lowest id on a tie; unsigned compare, no wraparound
    for (int s = 0; s < DEPTH; s++) begin
      if (shadow_valid[s]) begin
        live++;
        if (!have_best || shadow_arrival[s] < rep.oldest_time ||
            (shadow_arrival[s] == rep.oldest_time && shadow_id[s] < rep.oldest_id)) begin
          have_best       = 1'b1;
          rep.oldest_id   = shadow_id[s];
          rep.oldest_time = shadow_arrival[s];
        end
      end
    end
    rep.any_valid   = have_best;
    rep.entry_count = live[ENTRY_COUNT_W-1:0];
    return rep;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic queue_request(cmd_t c, logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
    swap_request_t rq;
    rq.cmd      = c;
    rq.item_id  = id;
    rq.now_tick = t;
    pending_requests.push_back(rq);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: offers the next pending request, holds it until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      // previous request taken (or none offered), so a new one may go up
      if (pending_requests.size() != 0 &&
          (calm_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
        staged_req       = pending_requests.pop_front();
        req_if.valid    <= 1'b1;
        req_if.cmd      <= staged_req.cmd;
        req_if.item_id  <= staged_req.item_id;
        req_if.now_tick <= staged_req.now_tick;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      // sender keeps offering while nothing drains
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result against the oldest owed report, then predicts
  // the report for any request taken on this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        results_seen <= results_seen + 1;
        if (owed_reports.size() == 0) begin
          $display("%0t: result with no request outstanding, status %0h id %0h time %0h",
                   $time, res_if.status, res_if.oldest_id, res_if.oldest_time);
          errors++;
        end else begin
          owed = owed_reports.pop_front();
          check_field("status", owed.status, res_if.status);
          check_field("any_valid", owed.any_valid, res_if.any_valid);
          check_field("oldest_id", owed.oldest_id, res_if.oldest_id);
          check_field("oldest_time", owed.oldest_time, res_if.oldest_time);
          check_field("entry_count", owed.entry_count, res_if.entry_count);
        end
      end
      if (req_if.valid && req_if.ready) begin
        accepted_requests <= accepted_requests + 1;
        taken_req.cmd      = cmd_t'(req_if.cmd);
        taken_req.item_id  = req_if.item_id;
        taken_req.now_tick = req_if.now_tick;
        owed = apply_swap_request(taken_req);
        status_hits[owed.status]++;
        if (owed.entry_count == DEPTH) full_reports++;
        owed_reports.push_back(owed);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("%0t: timeout, %0d requests still pending, %0d results owed",
               $time, pending_requests.size(), owed_reports.size());
      $display("oldest_entry_swap_table test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [ID_W-1:0]   id_pool[POOL_SIZE];
    logic [ID_W-1:0]   rid;
    logic [TIME_W-1:0] rtime;
    cmd_t              rcmd;
    bit                add_heavy;
    int                roll;

    // every block input known from time zero
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.cmd       = CMD_ADD;
    req_if.item_id   = '0;
    req_if.now_tick  = '0;
    res_if.ready     = 1'b0;
    for (int s = 0; s < DEPTH; s++) begin
      shadow_valid[s]   = 1'b0;
      shadow_id[s]      = '0;
      shadow_arrival[s] = '0;
    end

    // directed part
    queue_request(CMD_REMOVE, 16'h1234, 32'h0000_0000);      // remove from empty table
    queue_request(CMD_ADD,    16'hFFFF, 32'hFFFF_FFFF);      // largest id and time
    queue_request(CMD_ADD,    16'hFFFF, 32'h0000_0000);      // duplicate add
    queue_request(CMD_ADD,    16'h0000, 32'hFFFF_FFFF);      // tie on time, lower id wins
    for (int k = 1; k <= 14; k++) begin
      // fill up, one entry arriving at time zero
      queue_request(CMD_ADD, 16'h8000 | k[15:0], (k == 7) ? 32'h0 : 32'h1000_0000 * k);
    end
    queue_request(CMD_ADD,    16'h4242, 32'h0000_0005);      // full table refuses
    queue_request(CMD_ADD,    16'h0000, 32'h0000_0001);      // duplicate while full
    queue_request(CMD_REMOVE, 16'h5555, 32'hFFFF_FFFF);      // miss on a full table
    queue_request(CMD_REMOVE, 16'h8007, 32'h0000_0000);      // oldest leaves
    queue_request(CMD_ADD,    16'h4242, 32'h0000_0000);      // reuse of the freed slot
    queue_request(CMD_REMOVE, 16'hFFFF, 32'h0000_0000);
    queue_request(CMD_REMOVE, 16'h0000, 32'h0000_0000);

    // small id pool so adds collide and removes hit; extremes always present
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int p = 2; p < POOL_SIZE; p++) id_pool[p] = $urandom_range(0, 65535);

    // random part: alternating fill-heavy and drain-heavy runs of 64 requests
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      add_heavy = ((n / 64) % 2) == 0;
      roll      = $urandom_range(0, 99);
      rcmd      = (add_heavy ? (roll < 80) : (roll < 20)) ? CMD_ADD : CMD_REMOVE;
      roll      = $urandom_range(0, 99);
      rid       = (roll < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                              : 16'($urandom_range(0, 65535));
      roll      = $urandom_range(0, 99);
      if (roll < 35)      rtime = $urandom_range(0, 7);          // many equal times
      else if (roll < 42) rtime = 32'hFFFF_FFFF - $urandom_range(0, 3);
      else                rtime = $urandom();
      queue_request(rcmd, rid, rtime);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // drain: everything offered, taken and answered
    while (pending_requests.size() != 0 || req_if.valid || owed_reports.size() != 0)
      @(posedge clk);
    // then let the clock run on, to catch any stray result
    repeat (3 * (DEPTH + 3)) @(posedge clk);

    $display("covered %0d requests and %0d results, %0d with the table full",
             accepted_requests, results_seen, full_reports);
    $display("status mix: ok %0d, full %0d, not found %0d, duplicate %0d, errors %0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_NOT_FOUND],
             status_hits[ST_DUPLICATE], errors);
    if (errors == 0) begin
      $display("oldest_entry_swap_table test passed");
    end else begin
      $display("oldest_entry_swap_table test failed");
    end
    $finish;
  end

endmodule
